// ===== rtl/ssh_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Round constants, initial hash values and the controller state type.
// ----------------------------------------------------------------------------
package ssh_pkg;

  // Padding constants.
  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LENGTH_POS = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;

  // Input operation codes.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_CLOAD = 6'b000100,
    ST_CRND  = 6'b001000,
    ST_CFIN  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  typedef logic [31:0] word_t;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== rtl/sha256_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Absorbs one message byte per beat into a block memory, compresses each full
// block in 64 rounds and pads the message on finish.
// ----------------------------------------------------------------------------
// The 64th byte of a block starts a compression (load, 64 rounds, hash update),
//   during which input beats are stalled.
// A finish beat writes the padding one byte per cycle up to the block end,
//   runs one or two compressions, then shows 8 digest beats.
// Reset: asynchronous, active low; the hash returns to its initial values and
//   the counters clear. Block memory contents are not reset.
module sha256_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic        last_word_o
);

  ssh_pkg::state_e state_q, state_d;

  ssh_pkg::word_t hash_q [8];
  ssh_pkg::word_t v_q    [8];
  ssh_pkg::word_t win_q  [16];

  logic [5:0]  count_q;
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;
  logic        pad_q;
  logic        final_q;
  logic        mark_q;
  logic [2:0]  idx_q;

  // Block memory, 16 big-endian words written one byte at a time.
  logic [31:0] buf_mem [16];
  logic        mem_we;
  logic [5:0]  mem_waddr;
  logic [7:0]  mem_wdata;
  logic [3:0]  mem_raddr;
  logic [31:0] mem_rdata_q;

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign in_stall_o    = (state_q != ssh_pkg::ST_IDLE);
  assign out_valid_o   = (state_q == ssh_pkg::ST_EMIT);
  assign digest_word_o = hash_q[idx_q];
  assign last_word_o   = (idx_q == 3'd7);

  // Padding byte: the mark first, the bit length at the tail of the last block.
  logic [7:0] fill_byte;
  always_comb begin
    fill_byte = 8'h00;
    if (mark_q) begin
      fill_byte = ssh_pkg::PAD_MARK;
    end else if (final_q && count_q >= ssh_pkg::LENGTH_POS) begin
      fill_byte = bits_q[8 * (7 - count_q[2:0]) +: 8];
    end
  end

  // Memory write and read port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q;
    mem_wdata = data_byte_i;
    if (in_acc && operation_i == ssh_pkg::OP_ABSORB) begin
      mem_we = 1'b1;
    end else if (state_q == ssh_pkg::ST_PAD) begin
      mem_we    = 1'b1;
      mem_wdata = fill_byte;
    end
    mem_raddr = (state_q == ssh_pkg::ST_CRND) ? (rnd_q[3:0] + 4'd1) : 4'd0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      buf_mem[mem_waddr[5:2]][8 * (3 - mem_waddr[1:0]) +: 8] <= mem_wdata;
    end
    mem_rdata_q <= buf_mem[mem_raddr];
  end

  // Message schedule word and one compression round.
  ssh_pkg::word_t wt, s0, s1, big0, big1, ch, maj, t1, t2;
  always_comb begin
    s0 = {win_q[1][6:0], win_q[1][31:7]} ^ {win_q[1][17:0], win_q[1][31:18]}
         ^ (win_q[1] >> 3);
    s1 = {win_q[14][16:0], win_q[14][31:17]} ^ {win_q[14][18:0], win_q[14][31:19]}
         ^ (win_q[14] >> 10);
    wt = (rnd_q < 6'd16) ? mem_rdata_q : (s1 + win_q[9] + s0 + win_q[0]);
    big1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
           ^ {v_q[4][24:0], v_q[4][31:25]};
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + big1 + ch + ssh_pkg::ROUND_K[rnd_q] + wt;
    big0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
           ^ {v_q[0][21:0], v_q[0][31:22]};
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = big0 + maj;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ssh_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (operation_i == ssh_pkg::OP_FINISH) begin
            state_d = ssh_pkg::ST_PAD;
          end else if (count_q == ssh_pkg::LAST_POS) begin
            state_d = ssh_pkg::ST_CLOAD;
          end
        end
      end
      ssh_pkg::ST_PAD: begin
        if (count_q == ssh_pkg::LAST_POS) state_d = ssh_pkg::ST_CLOAD;
      end
      ssh_pkg::ST_CLOAD: state_d = ssh_pkg::ST_CRND;
      ssh_pkg::ST_CRND: begin
        if (rnd_q == 6'd63) state_d = ssh_pkg::ST_CFIN;
      end
      ssh_pkg::ST_CFIN: begin
        if (!pad_q)       state_d = ssh_pkg::ST_IDLE;
        else if (final_q) state_d = ssh_pkg::ST_EMIT;
        else              state_d = ssh_pkg::ST_PAD;
      end
      ssh_pkg::ST_EMIT: begin
        if (out_acc && idx_q == 3'd7) state_d = ssh_pkg::ST_IDLE;
      end
      default: state_d = ssh_pkg::ST_IDLE;
    endcase
  end

  // Control and hash registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssh_pkg::ST_IDLE;
      count_q <= '0;
      bits_q  <= '0;
      rnd_q   <= '0;
      pad_q   <= 1'b0;
      final_q <= 1'b0;
      mark_q  <= 1'b0;
      idx_q   <= '0;
      for (int i = 0; i < 8; i++) hash_q[i] <= ssh_pkg::INIT_HASH[i];
    end else begin
      state_q <= state_d;
      case (state_q)
        ssh_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (operation_i == ssh_pkg::OP_FINISH) begin
              pad_q   <= 1'b1;
              mark_q  <= 1'b1;
              final_q <= (count_q < ssh_pkg::LENGTH_POS);
            end else begin
              count_q <= count_q + 6'd1;
              bits_q  <= bits_q + 64'd8;
            end
          end
        end
        ssh_pkg::ST_PAD: begin
          mark_q  <= 1'b0;
          count_q <= count_q + 6'd1;
        end
        ssh_pkg::ST_CLOAD: rnd_q <= '0;
        ssh_pkg::ST_CRND:  rnd_q <= rnd_q + 6'd1;
        ssh_pkg::ST_CFIN: begin
          for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
          if (pad_q) final_q <= 1'b1;
          idx_q <= '0;
        end
        ssh_pkg::ST_EMIT: begin
          if (out_acc) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_q[i] <= ssh_pkg::INIT_HASH[i];
              count_q <= '0;
              bits_q  <= '0;
              pad_q   <= 1'b0;
              final_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working variables and the schedule window.
  always_ff @(posedge clk_i) begin
    if (state_q == ssh_pkg::ST_CLOAD) begin
      for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
    end else if (state_q == ssh_pkg::ST_CRND) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
      win_q[15] <= wt;
    end
  end

endmodule

// ===== rtl/ssh_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher port checker
// Watches the top-level ports for digest sequencing and interlock rules.
// ----------------------------------------------------------------------------
module ssh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        operation_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic        last_word_o
);

  // No input beat is taken while digest words are shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted during digest output");

  // A digest word that is not the last is followed by another one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_word_o) |=> out_valid_o)
    else $error("digest sequence broken");

  // A finish beat never yields a digest in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && operation_i) |=> !out_valid_o)
    else $error("digest appeared without compression");

  // A stalled digest beat holds its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(digest_word_o)))
    else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher_top ssh_checker u_ssh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .operation_i   (operation_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .digest_word_o (digest_word_o),
  .last_word_o   (last_word_o)
);
